// File: src/mgb_pkg.sv
// Shared constants of the maze backtracker: field widths, action and event codes,
// direction codes and door bit masks.
// No dependencies.
package mgb_pkg;

    localparam int FIELD_W    = 5;
    localparam int DIRW       = 2;
    localparam int ACT_W      = 2;
    localparam int KIND_W     = 3;
    localparam int DOOR_W     = 4;
    localparam int VIS_W      = 11;
    localparam int GRID_W     = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd1;

    localparam logic [KIND_W-1:0] EV_CARVED = 3'd0;
    localparam logic [KIND_W-1:0] EV_RETRY  = 3'd1;
    localparam logic [KIND_W-1:0] EV_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] EV_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] EV_INFO   = 3'd4;

    localparam logic [DIRW-1:0] DIR_WEST  = 2'd0;
    localparam logic [DIRW-1:0] DIR_EAST  = 2'd1;
    localparam logic [DIRW-1:0] DIR_SOUTH = 2'd2;
    localparam logic [DIRW-1:0] DIR_NORTH = 2'd3;

    localparam logic [DOOR_W-1:0] DOOR_NORTH = 4'b0001;
    localparam logic [DOOR_W-1:0] DOOR_SOUTH = 4'b0010;
    localparam logic [DOOR_W-1:0] DOOR_EAST  = 4'b0100;
    localparam logic [DOOR_W-1:0] DOOR_WEST  = 4'b1000;

    localparam logic [CFG_ADDR_W-1:0] ADDR_GRID_SIDE  = 3'd0;
    localparam logic [GRID_W-1:0]     GRID_SIDE_RESET = 6'd32;

endpackage

// File: src/maze_backtracker_generator.sv
// A read request passes through ST_RDOUT and ST_EMIT; a step makes five door map reads
// through its single read port, then the carve writes or the stack pop; a start
// first clears the whole door map, then reports its start cell.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset is synchronous: control state clears, then a clearing pass zeroes the
// whole door map with s_axis_tready low.
module maze_backtracker_generator #(
    parameter int MAX_SIDE = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cell_row [4:0], cell_col [9:5], random_dir [11:10]
    input  logic [mgb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action [1:0]
    input  logic [mgb_pkg::ACT_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pos_row [4:0], pos_col [9:5], door_bits [13:10], visited_count [24:14]
    output logic [mgb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // event_kind [2:0]
    output logic [mgb_pkg::KIND_W-1:0]        m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mgb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [mgb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mgb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mgb_pkg::*;

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int VW    = $clog2(CELLS + 1);
    localparam int XW    = (SW > FIELD_W) ? SW : FIELD_W;
    localparam int SE_W  = 2 * CW;

    localparam logic [2:0] RD_CUR = 3'd0;
    localparam logic [2:0] RD_N   = 3'd1;
    localparam logic [2:0] RD_S   = 3'd2;
    localparam logic [2:0] RD_W   = 3'd3;
    localparam logic [2:0] RD_E   = 3'd4;
    localparam logic [2:0] RD_END = 3'd5;

    localparam int FN = 0;
    localparam int FS = 1;
    localparam int FW = 2;
    localparam int FE = 3;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_RDOUT  = 9'b000000100,
        ST_NBR    = 9'b000001000,
        ST_DECIDE = 9'b000010000,
        ST_POP    = 9'b000100000,
        ST_POPRD  = 9'b001000000,
        ST_CARVE  = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(MAX_SIDE) + AW'(col);
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_clr_start, n_clr_start;
    logic [2:0]         r_rd_idx, n_rd_idx;
    logic [CW-1:0]      r_cur_row, n_cur_row, r_cur_col, n_cur_col;
    logic [AW-1:0]      r_top, n_top;
    logic [VW-1:0]      r_visited, n_visited;
    logic [FIELD_W-1:0] r_in_row, n_in_row, r_in_col, n_in_col;
    logic [DIRW-1:0]    r_dir, n_dir;
    logic               r_in_fits, n_in_fits;
    logic [DOOR_W-1:0]  r_cur_door, n_cur_door;
    logic [3:0]         r_free, n_free;
    logic [CW-1:0]      r_nxt_row, n_nxt_row, r_nxt_col, n_nxt_col;
    logic [DOOR_W-1:0]  r_there, n_there;
    logic [KIND_W-1:0]  r_res_kind, n_res_kind;
    logic [FIELD_W-1:0] r_res_row, n_res_row, r_res_col, n_res_col;
    logic [DOOR_W-1:0]  r_res_door, n_res_door;
    logic               r_out_valid, n_out_valid;
    logic [KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic [GRID_W-1:0]  r_grid_side;
    logic [SW-1:0]      r_side, n_side;
    logic [VW-1:0]      r_side_sq;

    logic               door_we, door_re;
    logic [AW-1:0]      door_waddr, door_raddr;
    logic [DOOR_W-1:0]  door_wdata, door_rdata;
    logic               stk_we, stk_re;
    logic [AW-1:0]      stk_waddr, stk_raddr;
    logic [SE_W-1:0]    stk_wdata, stk_rdata;

    logic [FIELD_W-1:0] in_row, in_col;
    logic [DIRW-1:0]    in_dir;
    logic               in_fits;
    logic               north_ok, south_ok, west_ok, east_ok;
    logic [CW-1:0]      row_up, row_dn, col_lf, col_rt;
    logic [AW-1:0]      cur_addr, nbr_addr, push_idx;
    logic [CW-1:0]      sat_row, sat_col, pop_row, pop_col;
    logic               fin, go;
    logic [CW-1:0]      go_row, go_col;
    logic [DOOR_W-1:0]  go_here, go_there;
    logic               cfg_wr;

    mgb_sdp_ram #(.DEPTH(CELLS), .WIDTH(DOOR_W)) u_door_map (
        .i_clk(i_clk), .i_we(door_we), .i_waddr(door_waddr), .i_wdata(door_wdata),
        .i_re(door_re), .i_raddr(door_raddr), .o_rdata(door_rdata)
    );

    mgb_sdp_ram #(.DEPTH(CELLS), .WIDTH(SE_W)) u_path_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_re(stk_re), .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GRID_SIDE) ? CFG_DATA_W'(r_grid_side) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= GRID_SIDE_RESET;
        end else if (cfg_wr && paddr == ADDR_GRID_SIDE) begin
            r_grid_side <= pwdata[GRID_W-1:0];
        end
    end

    always_comb begin
        if (r_grid_side == '0) begin
            n_side = SW'(1);
        end else if (8'(r_grid_side) > 8'(MAX_SIDE)) begin
            n_side = SW'(MAX_SIDE);
        end else begin
            n_side = SW'(r_grid_side);
        end
    end

    always_ff @(posedge i_clk) begin
        r_side    <= n_side;
        r_side_sq <= VW'(r_side) * VW'(r_side);
    end

    // Input fields and position helpers.
    assign in_row  = s_axis_tdata[FIELD_W-1:0];
    assign in_col  = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign in_dir  = s_axis_tdata[2*FIELD_W+DIRW-1:2*FIELD_W];
    assign in_fits = (XW'(in_row) < XW'(MAX_SIDE)) && (XW'(in_col) < XW'(MAX_SIDE));

    assign north_ok = (r_cur_row != '0);
    assign south_ok = (SW'(r_cur_row) + SW'(1)) < r_side;
    assign west_ok  = (r_cur_col != '0);
    assign east_ok  = (SW'(r_cur_col) + SW'(1)) < r_side;
    assign row_up = r_cur_row - CW'(1);
    assign row_dn = r_cur_row + CW'(1);
    assign col_lf = r_cur_col - CW'(1);
    assign col_rt = r_cur_col + CW'(1);

    assign cur_addr = cell_addr(r_cur_row, r_cur_col);
    assign sat_row  = (XW'(r_in_row) < XW'(r_side)) ? CW'(r_in_row) : CW'(r_side - SW'(1));
    assign sat_col  = (XW'(r_in_col) < XW'(r_side)) ? CW'(r_in_col) : CW'(r_side - SW'(1));
    assign pop_row  = stk_rdata[SE_W-1:CW];
    assign pop_col  = stk_rdata[CW-1:0];
    assign push_idx = (r_top != AW'(CELLS - 1)) ? r_top + AW'(1) : r_top;
    assign fin      = (r_visited == '0) || (r_visited >= r_side_sq);

    always_comb begin
        case (r_rd_idx)
            RD_N:    nbr_addr = north_ok ? cell_addr(row_up, r_cur_col) : cur_addr;
            RD_S:    nbr_addr = south_ok ? cell_addr(row_dn, r_cur_col) : cur_addr;
            RD_W:    nbr_addr = west_ok ? cell_addr(r_cur_row, col_lf) : cur_addr;
            RD_E:    nbr_addr = east_ok ? cell_addr(r_cur_row, col_rt) : cur_addr;
            default: nbr_addr = cur_addr;
        endcase
    end

    always_comb begin
        go       = 1'b0;
        go_row   = r_cur_row;
        go_col   = r_cur_col;
        go_here  = '0;
        go_there = '0;
        case (r_dir)
            DIR_WEST: begin
                if (r_free[FW]) begin
                    go = 1'b1; go_col = col_lf; go_here = DOOR_WEST; go_there = DOOR_EAST;
                end
            end
            DIR_EAST: begin
                if (r_free[FE]) begin
                    go = 1'b1; go_col = col_rt; go_here = DOOR_EAST; go_there = DOOR_WEST;
                end
            end
            DIR_SOUTH: begin
                if (r_free[FS]) begin
                    go = 1'b1; go_row = row_dn; go_here = DOOR_SOUTH; go_there = DOOR_NORTH;
                end
            end
            DIR_NORTH: begin
                if (r_free[FN]) begin
                    go = 1'b1; go_row = row_up; go_here = DOOR_NORTH; go_there = DOOR_SOUTH;
                end
            end
            default: begin
                go = 1'b0;
            end
        endcase
    end

    // Sequencer: a start clears the door map, a read answers one cell, and every step
    // reads the current cell and its four neighbors, then carves, pops or answers from those values.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_start = r_clr_start;
        n_rd_idx    = r_rd_idx;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_top       = r_top;
        n_visited   = r_visited;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_dir       = r_dir;
        n_in_fits   = r_in_fits;
        n_cur_door  = r_cur_door;
        n_free      = r_free;
        n_nxt_row   = r_nxt_row;
        n_nxt_col   = r_nxt_col;
        n_there     = r_there;
        n_res_kind  = r_res_kind;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        n_res_door  = r_res_door;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        door_we     = 1'b0;
        door_waddr  = '0;
        door_wdata  = '0;
        door_re     = 1'b0;
        door_raddr  = '0;
        stk_we      = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        stk_re      = 1'b0;
        stk_raddr   = '0;

        case (r_state)
            ST_CLEAR: begin
                door_we    = 1'b1;
                door_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    n_clr_addr  = '0;
                    n_clr_start = 1'b0;
                    if (r_clr_start) begin
                        n_cur_row  = sat_row;
                        n_cur_col  = sat_col;
                        n_top      = '0;
                        stk_we     = 1'b1;
                        stk_wdata  = {sat_row, sat_col};
                        n_visited  = VW'(1);
                        n_res_kind = EV_INFO;
                        n_res_row  = FIELD_W'(sat_row);
                        n_res_col  = FIELD_W'(sat_col);
                        n_res_door = '0;
                        n_state    = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in_row  = in_row;
                    n_in_col  = in_col;
                    n_dir     = in_dir;
                    n_in_fits = in_fits;
                    case (s_axis_tuser)
                        ACT_START: begin
                            n_clr_start = 1'b1;
                            n_clr_addr  = '0;
                            n_state     = ST_CLEAR;
                        end
                        ACT_STEP: begin
                            n_rd_idx = RD_CUR;
                            n_state  = ST_NBR;
                        end
                        default: begin
                            door_re    = 1'b1;
                            door_raddr = in_fits ? cell_addr(CW'(in_row), CW'(in_col)) : '0;
                            n_state    = ST_RDOUT;
                        end
                    endcase
                end
            end
            ST_RDOUT: begin
                n_res_kind = EV_INFO;
                n_res_row  = r_in_row;
                n_res_col  = r_in_col;
                n_res_door = r_in_fits ? door_rdata : '0;
                n_state    = ST_EMIT;
            end
            ST_NBR: begin
                door_re    = (r_rd_idx != RD_END);
                door_raddr = nbr_addr;
                case (r_rd_idx)
                    RD_N:    n_cur_door = door_rdata;
                    RD_S:    n_free[FN] = north_ok && (door_rdata == '0);
                    RD_W:    n_free[FS] = south_ok && (door_rdata == '0);
                    RD_E:    n_free[FW] = west_ok && (door_rdata == '0);
                    RD_END:  n_free[FE] = east_ok && (door_rdata == '0);
                    default: n_free     = r_free;
                endcase
                n_rd_idx = r_rd_idx + 3'd1;
                if (r_rd_idx == RD_END) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_res_row  = FIELD_W'(r_cur_row);
                n_res_col  = FIELD_W'(r_cur_col);
                n_res_door = r_cur_door;
                if (fin) begin
                    n_res_kind = EV_DONE;
                    n_state    = ST_EMIT;
                end else if (r_free == '0) begin
                    n_res_kind = EV_BACK;
                    if (r_top != '0) begin
                        n_top     = r_top - AW'(1);
                        stk_re    = 1'b1;
                        stk_raddr = r_top - AW'(1);
                        n_state   = ST_POP;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else if (go) begin
                    door_we    = 1'b1;
                    door_waddr = cur_addr;
                    door_wdata = r_cur_door | go_here;
                    n_nxt_row  = go_row;
                    n_nxt_col  = go_col;
                    n_there    = go_there;
                    n_state    = ST_CARVE;
                end else begin
                    n_res_kind = EV_RETRY;
                    n_state    = ST_EMIT;
                end
            end
            ST_POP: begin
                n_cur_row  = pop_row;
                n_cur_col  = pop_col;
                door_re    = 1'b1;
                door_raddr = cell_addr(pop_row, pop_col);
                n_state    = ST_POPRD;
            end
            ST_POPRD: begin
                n_res_kind = EV_BACK;
                n_res_row  = FIELD_W'(r_cur_row);
                n_res_col  = FIELD_W'(r_cur_col);
                n_res_door = door_rdata;
                n_state    = ST_EMIT;
            end
            ST_CARVE: begin
                door_we    = 1'b1;
                door_waddr = cell_addr(r_nxt_row, r_nxt_col);
                door_wdata = r_there;
                n_cur_row  = r_nxt_row;
                n_cur_col  = r_nxt_col;
                n_top      = push_idx;
                stk_we     = 1'b1;
                stk_waddr  = push_idx;
                stk_wdata  = {r_nxt_row, r_nxt_col};
                n_visited  = r_visited + VW'(1);
                n_res_kind = EV_CARVED;
                n_res_row  = FIELD_W'(r_nxt_row);
                n_res_col  = FIELD_W'(r_nxt_col);
                n_res_door = r_there;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_data  = OUT_DATA_W'({VIS_W'(r_visited), r_res_door,
                                               r_res_col, r_res_row});
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_start <= 1'b0;
            r_rd_idx    <= RD_CUR;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_top       <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_start <= n_clr_start;
            r_rd_idx    <= n_rd_idx;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_top       <= n_top;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_row   <= n_in_row;
        r_in_col   <= n_in_col;
        r_dir      <= n_dir;
        r_in_fits  <= n_in_fits;
        r_cur_door <= n_cur_door;
        r_free     <= n_free;
        r_nxt_row  <= n_nxt_row;
        r_nxt_col  <= n_nxt_col;
        r_there    <= n_there;
        r_res_kind <= n_res_kind;
        r_res_row  <= n_res_row;
        r_res_col  <= n_res_col;
        r_res_door <= n_res_door;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule

// File: src/mgb_sdp_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the door map and the path stack. No dependencies.
module mgb_sdp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mgb_checker.sv
// Port-level assertions for the maze backtracker, bound to the top level.
// Depends on mgb_pkg and on maze_backtracker_generator.
module mgb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mgb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [mgb_pkg::KIND_W-1:0]     m_axis_tuser
);
    import mgb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result changed or was dropped.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("Block not held busy for the clearing pass after reset.");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("A second request was taken while one is in work.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("A result appeared without a request in work.");

    a_carve_one_door: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == EV_CARVED |->
            $onehot(m_axis_tdata[2*FIELD_W +: DOOR_W]))
        else $error("A newly carved cell must show exactly one door.");

endmodule

bind maze_backtracker_generator mgb_checker u_mgb_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

// File: tb/maze_walk_checker.sv
`timescale 1ns / 1ps
// Result checker for the maze backtracker: follows the request, result and APB
// channels, keeps its own copy of the maze state and compares every result.
// Depends on mgb_pkg only.
module maze_walk_checker
    import mgb_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    // cell_row [4:0], cell_col [9:5], random_dir [11:10]
    input  logic [IN_DATA_W-1:0]  i_req_data,
    // action [1:0]
    input  logic [ACT_W-1:0]      i_req_user,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    // pos_row [4:0], pos_col [9:5], door_bits [13:10], visited_count [24:14]
    input  logic [OUT_DATA_W-1:0] i_rsp_data,
    // event_kind [2:0]
    input  logic [KIND_W-1:0]     i_rsp_user,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int CELLS   = MAX_SIDE * MAX_SIDE;
    localparam int COL_LSB = FIELD_W;
    localparam int DIR_LSB = 2 * FIELD_W;
    localparam int DOOR_LSB = 2 * FIELD_W;
    localparam int VIS_LSB = DOOR_LSB + DOOR_W;
    localparam int PAD_LSB = VIS_LSB + VIS_W;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [DOOR_W-1:0]  doors;
        logic [VIS_W-1:0]   visited;
    } t_maze_event;

    logic [DOOR_W-1:0]  door_map [MAX_SIDE][MAX_SIDE];
    logic [FIELD_W-1:0] path_rows [CELLS];
    logic [FIELD_W-1:0] path_cols [CELLS];
    int unsigned        path_depth;
    int unsigned        walker_row;
    int unsigned        walker_col;
    int unsigned        cells_seen;
    logic [GRID_W-1:0]  side_reg;
    t_maze_event        expected_events [$];

    function automatic t_maze_event pack_event(input logic [KIND_W-1:0] kind,
                                               input int unsigned r, input int unsigned c,
                                               input logic [DOOR_W-1:0] doors);
        t_maze_event ev;
        ev.kind    = kind;
        ev.row     = r[FIELD_W-1:0];
        ev.col     = c[FIELD_W-1:0];
        ev.doors   = doors;
        ev.visited = cells_seen[VIS_W-1:0];
        return ev;
    endfunction

    function automatic t_maze_event next_walk_event(input logic [ACT_W-1:0] act,
                                                    input int unsigned row,
                                                    input int unsigned col,
                                                    input logic [DIRW-1:0] dir);
        int unsigned       side;
        int unsigned       nr;
        int unsigned       nc;
        bit                free_n;
        bit                free_s;
        bit                free_w;
        bit                free_e;
        bit                go;
        logic [DOOR_W-1:0] here_door;
        logic [DOOR_W-1:0] there_door;
        logic [DOOR_W-1:0] read_doors;
        side = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);

        if (act == ACT_START) begin
            foreach (door_map[r, c]) door_map[r][c] = '0;
            walker_row = (row < side) ? row : side - 1;
            walker_col = (col < side) ? col : side - 1;
            path_depth = 0;
            path_rows[0] = walker_row[FIELD_W-1:0];
            path_cols[0] = walker_col[FIELD_W-1:0];
            cells_seen = 1;
            return pack_event(EV_INFO, walker_row, walker_col,
                              door_map[walker_row][walker_col]);
        end

        if (act != ACT_STEP) begin
            read_doors = '0;
            if (row < MAX_SIDE && col < MAX_SIDE) read_doors = door_map[row][col];
            return pack_event(EV_INFO, row, col, read_doors);
        end

        if (cells_seen == 0 || cells_seen >= side * side) begin
            return pack_event(EV_DONE, walker_row, walker_col,
                              door_map[walker_row][walker_col]);
        end

        free_n = walker_row > 0 && door_map[walker_row-1][walker_col] == '0;
        free_s = walker_row + 1 < side && door_map[walker_row+1][walker_col] == '0;
        free_w = walker_col > 0 && door_map[walker_row][walker_col-1] == '0;
        free_e = walker_col + 1 < side && door_map[walker_row][walker_col+1] == '0;

        if (!(free_n || free_s || free_w || free_e)) begin
            if (path_depth > 0) begin
                path_depth--;
                walker_row = path_rows[path_depth];
                walker_col = path_cols[path_depth];
            end
            return pack_event(EV_BACK, walker_row, walker_col,
                              door_map[walker_row][walker_col]);
        end

        go = 1'b0;
        nr = walker_row;
        nc = walker_col;
        here_door = '0;
        there_door = '0;
        if (dir == DIR_WEST && free_w) begin
            go = 1'b1;
            nc = walker_col - 1;
            here_door = DOOR_WEST;
            there_door = DOOR_EAST;
        end else if (dir == DIR_EAST && free_e) begin
            go = 1'b1;
            nc = walker_col + 1;
            here_door = DOOR_EAST;
            there_door = DOOR_WEST;
        end else if (dir == DIR_SOUTH && free_s) begin
            go = 1'b1;
            nr = walker_row + 1;
            here_door = DOOR_SOUTH;
            there_door = DOOR_NORTH;
        end else if (dir == DIR_NORTH && free_n) begin
            go = 1'b1;
            nr = walker_row - 1;
            here_door = DOOR_NORTH;
            there_door = DOOR_SOUTH;
        end

        if (!go) begin
            return pack_event(EV_RETRY, walker_row, walker_col,
                              door_map[walker_row][walker_col]);
        end

        door_map[walker_row][walker_col] = door_map[walker_row][walker_col] | here_door;
        door_map[nr][nc] = door_map[nr][nc] | there_door;
        walker_row = nr;
        walker_col = nc;
        if (path_depth + 1 < CELLS) path_depth++;
        path_rows[path_depth] = walker_row[FIELD_W-1:0];
        path_cols[path_depth] = walker_col[FIELD_W-1:0];
        cells_seen++;
        return pack_event(EV_CARVED, walker_row, walker_col,
                          door_map[walker_row][walker_col]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_maze_event want;
        if (!i_rst_n) begin
            foreach (door_map[r, c]) door_map[r][c] = '0;
            path_depth = 0;
            walker_row = 0;
            walker_col = 0;
            cells_seen = 0;
            side_reg = GRID_SIDE_RESET;
            expected_events.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_GRID_SIDE) begin
                side_reg = i_pwdata[GRID_W-1:0];
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with no request waiting",
                                              i_rsp_user));
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", i_rsp_user, want.kind);
                    check_field("pos_row", i_rsp_data[COL_LSB-1:0], want.row);
                    check_field("pos_col", i_rsp_data[DOOR_LSB-1:COL_LSB], want.col);
                    check_field("door_bits", i_rsp_data[VIS_LSB-1:DOOR_LSB], want.doors);
                    check_field("visited_count", i_rsp_data[PAD_LSB-1:VIS_LSB], want.visited);
                    check_field("tdata padding", i_rsp_data[OUT_DATA_W-1:PAD_LSB], 0);
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_events.push_back(next_walk_event(i_req_user,
                                                          i_req_data[COL_LSB-1:0],
                                                          i_req_data[DIR_LSB-1:COL_LSB],
                                                          i_req_data[DIR_LSB+DIRW-1:DIR_LSB]));
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the maze backtracker: drives carve, start and read requests,
// APB writes of the grid side and result back-pressure, then prints the verdict.
// Depends on mgb_pkg, maze_backtracker_generator and maze_walk_checker.
module tb;
    import mgb_pkg::*;

    localparam int MAX_SIDE     = 32;
    localparam int TOTAL_ITEMS  = 1225;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 32;

    localparam logic [ACT_W-1:0] ACT_READ     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ_ALT = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [ACT_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int sent_items    = 0;
    int rx_stall_left = 0;
    bit quiet         = 1'b0;
    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    bit rx_hold_req   = 1'b0;

    maze_backtracker_generator #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    maze_walk_checker #(
        .MAX_SIDE(MAX_SIDE)
    ) u_walk_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .i_rsp_user  (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: short random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_stall_left = LONG_HOLD;
        end
        if ((cycle_count % 256) == 0) rx_gaps = $urandom_range(0, 2) != 0;
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && rx_gaps && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] row,
                                input logic [FIELD_W-1:0] col, input logic [DIRW-1:0] dir);
        int gap;
        if (!quiet && tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-2*FIELD_W-DIRW){1'b0}}, dir, col, row};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_items++;
        quiet = sent_items >= TOTAL_ITEMS - QUIET_ITEMS;
    endtask

    task automatic step(input logic [DIRW-1:0] dir);
        send_request(ACT_STEP, FIELD_W'($urandom_range(0, 31)),
                     FIELD_W'($urandom_range(0, 31)), dir);
    endtask

    task automatic start_at(input logic [FIELD_W-1:0] row, input logic [FIELD_W-1:0] col);
        send_request(ACT_START, row, col, DIRW'($urandom_range(0, 3)));
    endtask

    task automatic read_cell(input logic [FIELD_W-1:0] row, input logic [FIELD_W-1:0] col);
        send_request(ACT_READ, row, col, DIRW'($urandom_range(0, 3)));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic configure(input logic [GRID_W-1:0] side);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GRID_SIDE;
        pwdata  <= {{(CFG_DATA_W-GRID_W){1'b0}}, side};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int phase;
        int pick;
        int side;
        int eff;
        int burst;
        int i;
        phase = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A step before any start finds no maze and reports finished.
        step(DIR_EAST);
        read_cell(5'd31, 5'd31);
        send_request(ACT_READ_ALT, 5'd0, 5'd31, DIR_NORTH);

        // Side zero acts as one, and the start cell saturates into the grid.
        configure(6'd0);
        start_at(5'd31, 5'd31);
        step(DIR_SOUTH);

        // Side beyond the maximum acts as the maximum.
        configure(6'd63);
        start_at(5'd31, 5'd31);
        step(DIR_NORTH);
        step(DIR_WEST);
        step(DIR_SOUTH);

        // Retry on a blocked direction, then carve the whole 2x2 maze.
        configure(6'd2);
        start_at(5'd5, 5'd5);
        step(DIR_EAST);
        step(DIR_NORTH);
        step(DIR_WEST);
        step(DIR_SOUTH);
        step(DIR_WEST);

        // Dead end at a corner forces a backtrack.
        configure(6'd3);
        start_at(5'd0, 5'd1);
        step(DIR_WEST);
        step(DIR_SOUTH);
        step(DIR_EAST);
        step(DIR_EAST);
        step(DIR_NORTH);
        step(DIR_NORTH);

        // Shrinking the side below the visited count completes the maze.
        configure(6'd2);
        step(DIR_SOUTH);

        while (sent_items < TOTAL_ITEMS) begin
            phase++;
            pick = $urandom_range(0, 99);
            if (pick < 65) side = $urandom_range(2, 6);
            else if (pick < 82) side = $urandom_range(7, 12);
            else if (pick < 92) side = $urandom_range(13, 24);
            else if (pick < 95) side = MAX_SIDE;
            else if (pick < 98) side = $urandom_range(0, 1);
            else side = $urandom_range(33, 63);
            eff = (side == 0) ? 1 : ((side > MAX_SIDE) ? MAX_SIDE : side);
            configure(side[GRID_W-1:0]);
            tx_gaps = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 7) != 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    start_at(FIELD_W'($urandom_range(0, 31)), FIELD_W'($urandom_range(0, 31)));
                end else begin
                    start_at(FIELD_W'($urandom_range(0, eff - 1)),
                             FIELD_W'($urandom_range(0, eff - 1)));
                end
            end
            if (phase == 3) begin
                drain_results();
                rx_hold_req = 1'b1;
            end
            burst = eff * eff * 5;
            if (burst > 160) burst = 160;
            burst = burst + $urandom_range(0, 8);
            for (i = 0; i < burst && sent_items < TOTAL_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    step(DIRW'($urandom_range(0, 3)));
                end else if (pick < 95) begin
                    read_cell(FIELD_W'($urandom_range(0, 31)), FIELD_W'($urandom_range(0, 31)));
                end else begin
                    send_request(ACT_W'($urandom_range(0, 3)), FIELD_W'($urandom_range(0, 31)),
                                 FIELD_W'($urandom_range(0, 31)), DIRW'($urandom_range(0, 3)));
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
